>>> design/pts_pkg.sv
// Package for the polynomial trajectory sampler: field widths, item and
// command types, sequencer states and saturation helpers.
// Depends on nothing; every design file but pts_ram refers to it by scoped names.
package pts_pkg;

  localparam int unsigned DW         = 48;
  localparam int unsigned TW         = 32;
  localparam int unsigned SEG_W      = 6;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CIDX_W     = 3;
  localparam int unsigned J_W        = 4;
  localparam int unsigned FACT_W     = 8;
  localparam int unsigned NUM_ORDERS = 3;
  localparam int unsigned OUT_AXES   = 3;

  localparam logic signed [63:0] Q_MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN48 = -64'sh0000_8000_0000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WEIGHT,
    ST_MUL_HI,
    ST_SUM,
    ST_ADD,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                kind;
    logic [SEG_W-1:0]   seg;
    logic [AXIS_W-1:0]  axis;
    logic [CIDX_W-1:0]  cidx;
    logic [DW-1:0]      coeff;
    logic [TW-1:0]      tval;
    logic               seg_ok;
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic load_w;
    logic mul_lo;
    logic mul_hi;
    logic sum;
  } lane_ctl_t;

  function automatic logic signed [DW-1:0] sat48(input logic signed [63:0] v);
    logic signed [DW-1:0] r;
    if (v > Q_MAX48) begin
      r = Q_MAX48[DW-1:0];
    end else if (v < Q_MIN48) begin
      r = Q_MIN48[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // Derivative weight of the coefficient of power j for derivative order d.
  function automatic logic [FACT_W-1:0] weight(input logic [J_W-1:0] j,
                                               input logic [1:0] d);
    logic [FACT_W-1:0] jx;
    logic [FACT_W-1:0] r;
    jx = {{(FACT_W-J_W){1'b0}}, j};
    case (d)
      2'd0:    r = FACT_W'(1);
      2'd1:    r = jx;
      2'd2:    r = FACT_W'(jx * (jx - FACT_W'(1)));
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pts_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pts_lane.sv
// One Horner lane: weighted coefficient, split 48x32 time product in low and
// high halves, floor shift with saturation and saturating accumulate.
// Depends on pts_pkg.
module pts_lane (
  input  logic                                clk_i,
  input  pts_pkg::lane_ctl_t                  ctl_i,
  input  logic                                update_i,
  input  logic signed [pts_pkg::DW-1:0]       coeff_i,
  input  logic        [pts_pkg::FACT_W-1:0]   factor_i,
  input  logic        [pts_pkg::TW-1:0]       time_i,
  output logic signed [pts_pkg::DW-1:0]       acc_o
);

  logic signed [pts_pkg::DW-1:0] acc_q, w_q, m_q;
  logic signed [64:0] pl_q, ph_q;
  logic signed [56:0] wprod;
  logic signed [64:0] pl_d, ph_d;
  logic signed [81:0] full_prod;
  logic signed [57:0] shifted;
  logic signed [48:0] acc_sum;

  assign wprod   = coeff_i * $signed({1'b0, factor_i});
  assign pl_d    = acc_q * $signed({1'b0, time_i[15:0]});
  assign ph_d    = acc_q * $signed({1'b0, time_i[31:16]});
  assign full_prod = $signed({ph_q[64], ph_q, 16'b0}) + $signed({{17{pl_q[64]}}, pl_q});
  assign shifted = full_prod[81:24];
  assign acc_sum = $signed({m_q[47], m_q}) + $signed({w_q[47], w_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_w) begin
      w_q <= pts_pkg::sat48({{7{wprod[56]}}, wprod});
    end
    if (ctl_i.mul_lo) begin
      pl_q <= pl_d;
    end
    if (ctl_i.mul_hi) begin
      ph_q <= ph_d;
    end
    if (ctl_i.sum) begin
      m_q <= pts_pkg::sat48({{6{shifted[57]}}, shifted});
    end
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (update_i) begin
      acc_q <= pts_pkg::sat48({{15{acc_sum[48]}}, acc_sum});
    end
  end

  assign acc_o = acc_q;

endmodule

>>> design/pts_front.sv
// Front end: accepts items, drops loads that fall outside the store, flags
// evaluates of absent segments and queues commands for the back end.
// Depends on pts_pkg.
module pts_front #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned NUM_COEFFS   = 8,
  parameter int unsigned NUM_AXES     = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              operation_i,
  input  logic        [pts_pkg::SEG_W-1:0]  segment_i,
  input  logic        [pts_pkg::AXIS_W-1:0] axis_i,
  input  logic        [pts_pkg::CIDX_W-1:0] coeff_index_i,
  input  logic signed [pts_pkg::DW-1:0]     coeff_value_i,
  input  logic        [pts_pkg::TW-1:0]     time_value_i,
  output pts_pkg::cmd_t                     cmd_o,
  output logic                              cmd_empty_o,
  input  logic                              cmd_pop_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  pts_pkg::cmd_t  q_mem [DEPTH];
  pts_pkg::cmd_t  entry;
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           seg_ok, load_ok, keep, wr, rd;

  assign seg_ok  = 32'(segment_i) < MAX_SEGMENTS;
  assign load_ok = seg_ok && (32'(axis_i) < NUM_AXES) && (32'(coeff_index_i) < NUM_COEFFS);
  assign keep    = (operation_i == pts_pkg::OP_EVAL) || load_ok;

  assign full_o      = cnt_q == CW'(DEPTH);
  assign cmd_empty_o = cnt_q == '0;
  assign wr          = push_i && !full_o && keep;
  assign rd          = cmd_pop_i && !cmd_empty_o;

  always_comb begin
    entry.kind   = pts_pkg::op_e'(operation_i);
    entry.seg    = segment_i;
    entry.axis   = axis_i;
    entry.cidx   = coeff_index_i;
    entry.coeff  = coeff_value_i;
    entry.tval   = time_value_i;
    entry.seg_ok = seg_ok;
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

  assign cmd_o = q_mem[rd_ptr_q];

endmodule

>>> design/pts_back.sv
// Back end: carries out queued loads and evaluates. Owns the coefficient
// store, sequences three shared Horner lanes over the axes in turn and holds the result item.
// Depends on pts_pkg, pts_ram and pts_lane.
module pts_back #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned NUM_COEFFS   = 8,
  parameter int unsigned NUM_AXES     = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pts_pkg::cmd_t                 cmd_i,
  input  logic                          cmd_empty_i,
  output logic                          cmd_pop_o,
  output logic signed [pts_pkg::DW-1:0] res_o [pts_pkg::NUM_ORDERS][pts_pkg::OUT_AXES],
  output logic                          res_valid_o,
  input  logic                          res_pop_i
);

  localparam int unsigned SEGS  = (MAX_SEGMENTS < 64) ? MAX_SEGMENTS : 64;
  localparam int unsigned ROW   = NUM_AXES * NUM_COEFFS;
  localparam int unsigned DEPTH = SEGS * ROW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned JW    = $clog2(NUM_COEFFS);

  pts_pkg::state_e              state_q, state_d;
  logic [JW-1:0]                j_q, j_d;
  logic [pts_pkg::AXIS_W-1:0]   axis_q, axis_d;
  logic [pts_pkg::SEG_W-1:0]    seg_q;
  logic [pts_pkg::TW-1:0]       time_q;
  logic                         out_valid_q;
  logic signed [pts_pkg::DW-1:0] work_q [pts_pkg::NUM_ORDERS][pts_pkg::OUT_AXES];
  logic signed [pts_pkg::DW-1:0] out_q  [pts_pkg::NUM_ORDERS][pts_pkg::OUT_AXES];
  logic signed [pts_pkg::DW-1:0] lane_acc [pts_pkg::NUM_ORDERS];

  pts_pkg::lane_ctl_t ctl;
  logic               upd, work_clr, work_wr, out_load, start_eval;
  logic               ram_we, ram_re;
  logic [AW-1:0]      waddr, raddr;
  logic [pts_pkg::DW-1:0] rdata;

  assign waddr = AW'(AW'(cmd_i.seg) * AW'(ROW) + AW'(cmd_i.axis) * AW'(NUM_COEFFS)
                     + AW'(cmd_i.cidx));
  assign raddr = AW'(AW'(seg_q) * AW'(ROW) + AW'(axis_q) * AW'(NUM_COEFFS) + AW'(j_q));

  pts_ram #(
    .WIDTH(pts_pkg::DW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(cmd_i.coeff),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  for (genvar g = 0; g < pts_pkg::NUM_ORDERS; g++) begin : g_lane
    pts_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .update_i(upd && (pts_pkg::J_W'(j_q) >= pts_pkg::J_W'(g))),
      .coeff_i ($signed(rdata)),
      .factor_i(pts_pkg::weight(pts_pkg::J_W'(j_q), 2'(g))),
      .time_i  (time_q),
      .acc_o   (lane_acc[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    axis_d     = axis_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ctl        = '0;
    upd        = 1'b0;
    work_clr   = 1'b0;
    work_wr    = 1'b0;
    out_load   = 1'b0;
    start_eval = 1'b0;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == pts_pkg::OP_LOAD) begin
            ram_we = 1'b1;
          end else begin
            start_eval = 1'b1;
            work_clr   = 1'b1;
            ctl.clear  = 1'b1;
            axis_d     = '0;
            j_d        = JW'(NUM_COEFFS - 1);
            state_d    = cmd_i.seg_ok ? pts_pkg::ST_READ : pts_pkg::ST_DONE;
          end
        end
      end
      pts_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = pts_pkg::ST_WEIGHT;
      end
      pts_pkg::ST_WEIGHT: begin
        ctl.load_w = 1'b1;
        ctl.mul_lo = 1'b1;
        state_d    = pts_pkg::ST_MUL_HI;
      end
      pts_pkg::ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_d    = pts_pkg::ST_SUM;
      end
      pts_pkg::ST_SUM: begin
        ctl.sum = 1'b1;
        state_d = pts_pkg::ST_ADD;
      end
      pts_pkg::ST_ADD: begin
        upd = 1'b1;
        if (j_q == '0) begin
          state_d = pts_pkg::ST_STORE;
        end else begin
          j_d     = j_q - JW'(1);
          state_d = pts_pkg::ST_READ;
        end
      end
      pts_pkg::ST_STORE: begin
        work_wr   = 1'b1;
        ctl.clear = 1'b1;
        j_d       = JW'(NUM_COEFFS - 1);
        if (axis_q == pts_pkg::AXIS_W'(NUM_AXES - 1)) begin
          state_d = pts_pkg::ST_DONE;
        end else begin
          axis_d  = axis_q + pts_pkg::AXIS_W'(1);
          state_d = pts_pkg::ST_READ;
        end
      end
      pts_pkg::ST_DONE: begin
        if (!out_valid_q || res_pop_i) begin
          out_load = 1'b1;
          state_d  = pts_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::ST_IDLE;
      j_q         <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      axis_q  <= axis_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_eval) begin
      seg_q  <= cmd_i.seg;
      time_q <= cmd_i.tval;
    end
    for (int d = 0; d < pts_pkg::NUM_ORDERS; d++) begin
      for (int a = 0; a < pts_pkg::OUT_AXES; a++) begin
        if (work_clr) begin
          work_q[d][a] <= '0;
        end else if (work_wr && (axis_q == pts_pkg::AXIS_W'(a))) begin
          work_q[d][a] <= lane_acc[d];
        end
        if (out_load) begin
          out_q[d][a] <= work_q[d][a];
        end
      end
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

endmodule

>>> design/polynomial_trajectory_sampler.sv
// Top level of the polynomial trajectory sampler: front end with command
// queue and back end with coefficient store, Horner lanes and result register.
// Depends on pts_pkg, pts_front and pts_back.
//
//   Channel   Handshake          Fields
//   input     push / full        operation, segment, axis, coeff_index,
//                                coeff_value, time_value
//   result    empty / pop        pos_*, vel_*, acc_* for x, y, z
//
// A load is written to the coefficient store as it is popped from the head of the command queue.
// An evaluate runs the five-step Horner iteration of the shared lane set for
// each coefficient of each axis in turn.
// Reset clears the queues and the sequencer; the coefficient store is not cleared.
// A result that is not popped holds the back end, while the two-entry command
// queue keeps taking items until it is full.
module polynomial_trajectory_sampler #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned NUM_COEFFS   = 8,
  parameter int unsigned NUM_AXES     = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              operation_i,
  input  logic        [pts_pkg::SEG_W-1:0]  segment_i,
  input  logic        [pts_pkg::AXIS_W-1:0] axis_i,
  input  logic        [pts_pkg::CIDX_W-1:0] coeff_index_i,
  input  logic signed [pts_pkg::DW-1:0]     coeff_value_i,
  input  logic        [pts_pkg::TW-1:0]     time_value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pts_pkg::DW-1:0]     pos_x_o,
  output logic signed [pts_pkg::DW-1:0]     pos_y_o,
  output logic signed [pts_pkg::DW-1:0]     pos_z_o,
  output logic signed [pts_pkg::DW-1:0]     vel_x_o,
  output logic signed [pts_pkg::DW-1:0]     vel_y_o,
  output logic signed [pts_pkg::DW-1:0]     vel_z_o,
  output logic signed [pts_pkg::DW-1:0]     acc_x_o,
  output logic signed [pts_pkg::DW-1:0]     acc_y_o,
  output logic signed [pts_pkg::DW-1:0]     acc_z_o
);

  pts_pkg::cmd_t cmd;
  logic          cmd_empty, cmd_pop, res_valid;
  logic signed [pts_pkg::DW-1:0] res [pts_pkg::NUM_ORDERS][pts_pkg::OUT_AXES];

  pts_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .NUM_COEFFS  (NUM_COEFFS),
    .NUM_AXES    (NUM_AXES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .operation_i  (operation_i),
    .segment_i    (segment_i),
    .axis_i       (axis_i),
    .coeff_index_i(coeff_index_i),
    .coeff_value_i(coeff_value_i),
    .time_value_i (time_value_i),
    .cmd_o        (cmd),
    .cmd_empty_o  (cmd_empty),
    .cmd_pop_i    (cmd_pop)
  );

  pts_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .NUM_COEFFS  (NUM_COEFFS),
    .NUM_AXES    (NUM_AXES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .res_valid_o(res_valid),
    .res_pop_i  (pop && res_valid)
  );

  assign empty   = !res_valid;
  assign pos_x_o = res[0][0];
  assign pos_y_o = res[0][1];
  assign pos_z_o = res[0][2];
  assign vel_x_o = res[1][0];
  assign vel_y_o = res[1][1];
  assign vel_z_o = res[1][2];
  assign acc_x_o = res[2][0];
  assign acc_y_o = res[2][1];
  assign acc_z_o = res[2][2];

endmodule
